// ===== hdl/bcp_pkg.sv =====
// Package for the blitter copy setup block: payload structs for the request
// and the result beat. No dependencies.
package bcp_pkg;

    localparam int unsigned PosW   = 16;
    localparam int unsigned ShiftW = 4;

    typedef struct packed {
        logic [PosW-1:0] src_bit;
        logic [PosW-1:0] dst_bit;
        logic [PosW-1:0] span_width;
    } req_t;

    typedef struct packed {
        logic [PosW-1:0]   first_mask;
        logic [PosW-1:0]   last_mask;
        logic [PosW-1:0]   src_offset;
        logic [PosW-1:0]   dst_offset;
        logic [ShiftW-1:0] a_shift;
        logic [ShiftW-1:0] b_shift;
        logic [PosW-1:0]   span_bytes;
        logic              descending;
    } res_t;

endpackage

// ===== hdl/bcp_calc.sv =====
// Combinational setup calculation: masks, offsets, shifts, span, direction.
// Depends on bcp_pkg.
module bcp_calc (
    input  bcp_pkg::req_t req,
    output bcp_pkg::res_t res
);
    import bcp_pkg::*;

    // first word mask: leading pixels of a word dropped
    function automatic logic [PosW-1:0] head_mask(input logic [PosW-1:0] p);
        head_mask = 16'hFFFF >> p[3:0];
    endfunction

    // last word mask: top e+1 bits, e = bit index of the last pixel
    function automatic logic [PosW-1:0] tail_mask(input logic [PosW-1:0] last);
        tail_mask = ~(16'h7FFF >> last[3:0]);
    endfunction

    function automatic logic [PosW-1:0] word_bytes(input logic [PosW-1:0] p,
                                                   input logic [PosW-1:0] last);
        logic [PosW-1:0] diff;
        diff = {4'b0000, last[15:4]} - {4'b0000, p[15:4]};
        word_bytes = {diff[14:0], 1'b0} + 16'd2;
    endfunction

    logic [PosW-1:0]   src_last, dst_last;
    logic [PosW-1:0]   src_bytes, dst_bytes;
    logic [ShiftW-1:0] sd_shift, ds_shift;
    logic              desc;

    assign src_last  = req.src_bit + req.span_width - 16'd1;
    assign dst_last  = req.dst_bit + req.span_width - 16'd1;
    assign src_bytes = word_bytes(req.src_bit, src_last);
    assign dst_bytes = word_bytes(req.dst_bit, dst_last);
    assign sd_shift  = req.src_bit[3:0] - req.dst_bit[3:0];
    assign ds_shift  = req.dst_bit[3:0] - req.src_bit[3:0];
    assign desc      = req.dst_bit[3:0] < req.src_bit[3:0];

    always_comb begin
        res.descending = desc;
        if (desc) begin
            // offsets point at the last word, masks swapped
            res.span_bytes = src_bytes;
            res.a_shift    = sd_shift;
            res.b_shift    = sd_shift;
            res.src_offset = {3'b000, src_last[15:4], 1'b0};
            res.dst_offset = {3'b000, req.dst_bit[15:4], 1'b0} + src_bytes - 16'd2;
            res.first_mask = tail_mask(src_last);
            res.last_mask  = head_mask(req.src_bit);
        end else begin
            res.b_shift    = ds_shift;
            res.src_offset = {3'b000, req.src_bit[15:4], 1'b0};
            res.dst_offset = {3'b000, req.dst_bit[15:4], 1'b0};
            if (dst_bytes > src_bytes) begin
                res.span_bytes = dst_bytes;
                res.a_shift    = '0;
                res.first_mask = head_mask(req.dst_bit);
                res.last_mask  = tail_mask(dst_last);
            end else begin
                res.span_bytes = src_bytes;
                res.a_shift    = ds_shift;
                res.first_mask = head_mask(req.src_bit);
                res.last_mask  = tail_mask(src_last);
            end
        end
    end

endmodule

// ===== hdl/blit_copy_param_calc.sv =====
// Top level of the blitter copy setup block: input register, calculation,
// result register. Depends on bcp_pkg and bcp_calc.
//
//  channel   direction  fields
//  s_        in         src_bit, dst_bit, span_width
//  m_        out        first_mask, last_mask, src_offset, dst_offset,
//                       a_shift, b_shift, span_bytes, descending
//
// Each beat passes the input register, then the result register; one beat accepted every cycle while m_ is not stalled.
// The input register feeds bcp_calc, which sets the result register.
// A beat with zero span_width is accepted and dropped, producing no result.
// Reset clears both valid flags; payload registers are not reset.
// A stalled m_ side holds its beat while one more input beat is buffered.
module blit_copy_param_calc (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_src_bit,
    input  logic [15:0] s_dst_bit,
    input  logic [15:0] s_span_width,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_first_mask,
    output logic [15:0] m_last_mask,
    output logic [15:0] m_src_offset,
    output logic [15:0] m_dst_offset,
    output logic [3:0]  m_a_shift,
    output logic [3:0]  m_b_shift,
    output logic [15:0] m_span_bytes,
    output logic        m_descending
);
    import bcp_pkg::*;

    logic in_vld_reg, in_vld_next;
    req_t in_reg;
    logic out_vld_reg, out_vld_next;
    res_t out_reg;
    res_t calc_res;
    logic advance;
    logic s_fire;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_vld_next = in_vld_reg && !advance;
        if (s_fire) begin
            in_vld_next = s_span_width != '0;
        end
        out_vld_next = out_vld_reg && !m_ready;
        if (advance) begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg.src_bit    <= s_src_bit;
            in_reg.dst_bit    <= s_dst_bit;
            in_reg.span_width <= s_span_width;
        end
        if (advance) begin
            out_reg <= calc_res;
        end
    end

    bcp_calc u_calc (
        .req (in_reg),
        .res (calc_res)
    );

    assign m_valid      = out_vld_reg;
    assign m_first_mask = out_reg.first_mask;
    assign m_last_mask  = out_reg.last_mask;
    assign m_src_offset = out_reg.src_offset;
    assign m_dst_offset = out_reg.dst_offset;
    assign m_a_shift    = out_reg.a_shift;
    assign m_b_shift    = out_reg.b_shift;
    assign m_span_bytes = out_reg.span_bytes;
    assign m_descending = out_reg.descending;

    // zero-width beats never reach the calculation stage
    a_zero_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_span_width == '0 |=> !in_vld_reg)
        else $error("zero-width beat entered the pipeline");

    // a new result only appears after a valid input stage
    a_res_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_vld_reg))
        else $error("result valid without a buffered request");

    a_desc_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_descending |-> m_a_shift == m_b_shift)
        else $error("descending copy with unequal shifts");

    a_span_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_span_bytes[0])
        else $error("odd span in bytes");

endmodule

// ===== tb/tb_blit_copy_param_calc.sv =====
// Self-checking bench for blit_copy_param_calc: random and directed copy requests,
// with a scoreboard that predicts each setup beat and checks it. Depends on bcp_pkg.
module tb_blit_copy_param_calc;
    import bcp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_COUNT  = 900;
    localparam int DRAIN_CYCLES  = 8;

    class setup_scoreboard;
        res_t setups_due[$];
        int   mismatches;
        int   unexpected_beats;
        int   beats_checked;
        int   zero_spans;
        int   descending_seen;
        int   dst_follow_seen;
        int   src_follow_seen;

        function new();
            mismatches       = 0;
            unexpected_beats = 0;
            beats_checked    = 0;
            zero_spans       = 0;
            descending_seen  = 0;
            dst_follow_seen  = 0;
            src_follow_seen  = 0;
        endfunction

        function int pending();
            return setups_due.size();
        endfunction

        // Returns 0 for a zero-width request, which yields no beat.
        function bit predict_setup(req_t r, output res_t s);
            logic [15:0] src_last, dst_last, src_words, dst_words;
            logic [15:0] follow, follow_last, head_m, tail_m;
            s = '0;
            if (r.span_width == 16'd0) return 1'b0;
            src_last  = r.src_bit + r.span_width - 16'd1;
            dst_last  = r.dst_bit + r.span_width - 16'd1;
            src_words = ((src_last >> 4) - (r.src_bit >> 4)) * 16'd2 + 16'd2;
            dst_words = ((dst_last >> 4) - (r.dst_bit >> 4)) * 16'd2 + 16'd2;
            if (r.dst_bit[3:0] < r.src_bit[3:0]) begin
                s.descending = 1'b1;
                s.span_bytes = src_words;
                s.a_shift    = r.src_bit[3:0] - r.dst_bit[3:0];
                s.b_shift    = s.a_shift;
                s.src_offset = (src_last >> 4) * 16'd2;
                s.dst_offset = (r.dst_bit >> 4) * 16'd2 + src_words - 16'd2;
                follow       = r.src_bit;
                follow_last  = src_last;
            end else begin
                s.descending = 1'b0;
                s.b_shift    = r.dst_bit[3:0] - r.src_bit[3:0];
                s.src_offset = (r.src_bit >> 4) * 16'd2;
                s.dst_offset = (r.dst_bit >> 4) * 16'd2;
                if (dst_words > src_words) begin
                    s.span_bytes = dst_words;
                    s.a_shift    = 4'd0;
                    follow       = r.dst_bit;
                    follow_last  = dst_last;
                end else begin
                    s.span_bytes = src_words;
                    s.a_shift    = s.b_shift;
                    follow       = r.src_bit;
                    follow_last  = src_last;
                end
            end
            head_m = 16'hffff >> follow[3:0];
            // top (end+1) bits set; an end on bit 15 gives a full mask
            tail_m = ~(16'hffff >> ({1'b0, follow_last[3:0]} + 5'd1));
            if (s.descending) begin
                s.first_mask = tail_m;
                s.last_mask  = head_m;
            end else begin
                s.first_mask = head_m;
                s.last_mask  = tail_m;
            end
            return 1'b1;
        endfunction

        function void note_request(req_t r);
            res_t s;
            if (!predict_setup(r, s)) begin
                zero_spans++;
                return;
            end
            if (s.descending) descending_seen++;
            else if (s.a_shift == 4'd0 && s.b_shift != 4'd0) dst_follow_seen++;
            else src_follow_seen++;
            setups_due.push_back(s);
        endfunction

        function void check_beat(res_t got);
            res_t  want;
            string bad;
            bad = "";
            if (setups_due.size() == 0) begin
                unexpected_beats++;
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result beat %h", $realtime, got);
                return;
            end
            want = setups_due.pop_front();
            beats_checked++;
            if (got.first_mask !== want.first_mask) bad = {bad, " first_mask"};
            if (got.last_mask  !== want.last_mask)  bad = {bad, " last_mask"};
            if (got.src_offset !== want.src_offset) bad = {bad, " src_offset"};
            if (got.dst_offset !== want.dst_offset) bad = {bad, " dst_offset"};
            if (got.a_shift    !== want.a_shift)    bad = {bad, " a_shift"};
            if (got.b_shift    !== want.b_shift)    bad = {bad, " b_shift"};
            if (got.span_bytes !== want.span_bytes) bad = {bad, " span_bytes"};
            if (got.descending !== want.descending) bad = {bad, " descending"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] mismatch in%s", $realtime, bad);
                    $display("    want fm=%h lm=%h so=%h do=%h a=%h b=%h sz=%h desc=%b",
                             want.first_mask, want.last_mask, want.src_offset,
                             want.dst_offset, want.a_shift, want.b_shift,
                             want.span_bytes, want.descending);
                    $display("    got  fm=%h lm=%h so=%h do=%h a=%h b=%h sz=%h desc=%b",
                             got.first_mask, got.last_mask, got.src_offset,
                             got.dst_offset, got.a_shift, got.b_shift,
                             got.span_bytes, got.descending);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_src_bit;
    logic [15:0] s_dst_bit;
    logic [15:0] s_span_width;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_first_mask;
    logic [15:0] m_last_mask;
    logic [15:0] m_src_offset;
    logic [15:0] m_dst_offset;
    logic [3:0]  m_a_shift;
    logic [3:0]  m_b_shift;
    logic [15:0] m_span_bytes;
    logic        m_descending;

    setup_scoreboard sb;
    int cycle_count = 0;
    int beats_taken = 0;
    int requests_sent = 0;

    blit_copy_param_calc dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_src_bit    (s_src_bit),
        .s_dst_bit    (s_dst_bit),
        .s_span_width (s_span_width),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_first_mask (m_first_mask),
        .m_last_mask  (m_last_mask),
        .m_src_offset (m_src_offset),
        .m_dst_offset (m_dst_offset),
        .m_a_shift    (m_a_shift),
        .m_b_shift    (m_b_shift),
        .m_span_bytes (m_span_bytes),
        .m_descending (m_descending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d setups outstanding",
                     cycle_count, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result monitor: values read right after the edge are the ones sampled by it
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_beat({m_first_mask, m_last_mask, m_src_offset, m_dst_offset,
                           m_a_shift, m_b_shift, m_span_bytes, m_descending});
            beats_taken <= beats_taken + 1;
        end
    end

    function automatic int draw_wait(bit no_idle);
        if (no_idle) return 0;
        return $urandom_range(0, 9);
    endfunction

    task automatic send_request(input logic [15:0] src, input logic [15:0] dst,
                                input logic [15:0] wid, input int gap);
        req_t r;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_src_bit    <= src;
        s_dst_bit    <= dst;
        s_span_width <= wid;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r.src_bit    = src;
        r.dst_bit    = dst;
        r.span_width = wid;
        sb.note_request(r);
        requests_sent++;
    endtask

    task automatic take_results();
        int stall;
        forever begin
            stall = draw_wait(((beats_taken / 50) % 4) == 2);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    endtask

    task automatic drain_setups();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] src, dst, wid;
        int kind, done_random, idx;
        sb = new();
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_src_bit    <= 16'd0;
        s_dst_bit    <= 16'd0;
        s_span_width <= 16'd0;
        m_ready      <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        fork
            take_results();
        join_none

        // directed: extremes, both directions, both mask sources, aligned end, wrap
        send_request(16'd0,     16'd0,     16'd1,     draw_wait(0));
        send_request(16'd0,     16'd0,     16'd0,     draw_wait(0));
        send_request(16'hffff,  16'hffff,  16'd0,     0);
        send_request(16'd0,     16'd0,     16'd16,    0);
        send_request(16'd0,     16'd0,     16'hffff,  0);
        send_request(16'hffff,  16'hffff,  16'hffff,  draw_wait(0));
        send_request(16'hffff,  16'd0,     16'd1,     0);
        send_request(16'd0,     16'hffff,  16'd1,     0);
        send_request(16'd5,     16'd2,     16'd30,    draw_wait(0));
        send_request(16'd15,    16'd0,     16'd1,     0);
        send_request(16'd15,    16'd16,    16'd17,    0);
        send_request(16'd5,     16'd3,     16'd11,    0);
        send_request(16'd0,     16'd15,    16'd2,     draw_wait(0));
        send_request(16'd3,     16'd5,     16'd10,    0);
        send_request(16'd3,     16'd3,     16'd13,    0);
        send_request(16'd32,    16'd47,    16'd100,   0);
        send_request(16'd65530, 16'd100,   16'd20,    draw_wait(0));
        send_request(16'd100,   16'd65530, 16'd20,    0);
        send_request(16'd65533, 16'd65521, 16'd40,    0);
        send_request(16'haaaa,  16'h5555,  16'h5555,  0);
        send_request(16'h5555,  16'haaaa,  16'haaaa,  draw_wait(0));
        send_request(16'h8000,  16'h7fff,  16'h8000,  0);
        send_request(16'h7fff,  16'h8000,  16'h7fff,  0);
        s_valid <= 1'b0;
        drain_setups();

        done_random = 0;
        idx = 0;
        while (done_random < RANDOM_COUNT) begin
            kind = $urandom_range(0, 99);
            src  = 16'($urandom);
            dst  = 16'($urandom);
            if (kind < 50) begin
                wid = 16'($urandom_range(1, 48));
            end else if (kind < 65) begin
                wid = 16'($urandom_range(1, 400));
            end else if (kind < 75) begin
                wid = 16'($urandom);
            end else if (kind < 85) begin
                src = 16'(16'hffff - $urandom_range(0, 40));
                if ($urandom_range(0, 1)) dst = 16'(16'hffff - $urandom_range(0, 40));
                wid = 16'($urandom_range(1, 80));
            end else if (kind < 93) begin
                // run ends on the last bit of a word
                wid = 16'((16'd16 - src[3:0]) + 16'd16 * $urandom_range(0, 5));
            end else begin
                wid = 16'd0;
            end
            if (done_random == RANDOM_COUNT / 2 && wid != 16'd0) begin
                s_valid <= 1'b0;
                drain_setups();
            end
            send_request(src, dst, wid, draw_wait(((idx / 60) % 4) == 3));
            if (wid != 16'd0) done_random++;
            idx++;
        end
        s_valid <= 1'b0;
        drain_setups();

        $display("%0d requests (%0d zero width), %0d setups checked",
                 requests_sent, sb.zero_spans, sb.beats_checked);
        $display("descending %0d, ascending dst-masked %0d, src-masked %0d",
                 sb.descending_seen, sb.dst_follow_seen, sb.src_follow_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d unexpected beats, %0d setups missing",
                     sb.mismatches, sb.unexpected_beats, sb.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
